@@ rtl/core/ppe_pkg.sv @@
package ppe_pkg;

    localparam int POOL_SLOTS = 64;
    localparam int SLOT_W     = 6;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_SPAWN = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_DRAW  = 2'd3
    } cmd_t;

    localparam logic [15:0] GRAVITY_RESET = 16'sd5;
    localparam logic [0:0]  REG_GRAVITY   = 1'b0;

    // one particle record as held in the slot memory
    typedef struct packed {
        logic [23:0] x;
        logic [23:0] y;
        logic [15:0] vx;
        logic [15:0] vy;
        logic [15:0] life;
        logic [15:0] total;
        logic [7:0]  size;
        logic [31:0] color;
    } part_t;

    // saturating add of a 16-bit signed step to a 24-bit signed value
    function automatic logic [23:0] sat24(input logic [23:0] a, input logic [15:0] b);
        logic [24:0] s;
        begin
            s = {a[23], a} + {{9{b[15]}}, b};
            if (s[24] != s[23])
                sat24 = s[24] ? 24'h800000 : 24'h7FFFFF;
            else
                sat24 = s[23:0];
        end
    endfunction

    function automatic logic [15:0] sat16(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        begin
            s = {a[15], a} + {b[15], b};
            if (s[16] != s[15])
                sat16 = s[16] ? 16'h8000 : 16'h7FFF;
            else
                sat16 = s[15:0];
        end
    endfunction

    // signed divide by 256, rounded toward zero
    function automatic logic [15:0] trunc_px(input logic [23:0] v);
        logic [23:0] t;
        begin
            t = v + ((v[23] && (v[7:0] != 8'd0)) ? 24'd256 : 24'd0);
            trunc_px = t[23:8];
        end
    endfunction

endpackage

@@ rtl/core/ppe_div.sv @@
// 24-bit numerator / 16-bit denominator, one quotient bit per cycle
module ppe_div
    import ppe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [23:0] num,
    input  logic [15:0] den,
    output logic        done,
    output logic [7:0]  quo
);
    logic [15:0] rem_reg, rem_next;
    logic [23:0] n_reg, n_next;
    logic [15:0] d_reg, d_next;
    logic [7:0]  q_reg, q_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [16:0] trial;
    logic [16:0] diff;

    always_comb
    begin
        rem_next  = rem_reg;
        n_next    = n_reg;
        d_next    = d_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        trial     = {rem_reg, n_reg[23]};
        diff      = trial - {1'b0, d_reg};
        if (go)
        begin
            rem_next = 16'd0;
            n_next   = num;
            d_next   = den;
            q_next   = 8'd0;
            cnt_next = 5'd24;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            n_next = {n_reg[22:0], 1'b0};
            if (!diff[16])
            begin
                rem_next = diff[15:0];
                q_next   = {q_reg[6:0], 1'b1};
            end
            else
            begin
                rem_next = trial[15:0];
                q_next   = {q_reg[6:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        n_reg   <= n_next;
        d_reg   <= d_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;
endmodule

@@ rtl/core/particle_pool_engine_unit.sv @@
// Particle pool engine: a pool of 64 particle slots driven by commands.
// Channels: start/busy command port (command plus spawn and tick fields),
// a result strobe with its payload ports, and an APB register port holding
// gravity_step at byte address 0 (reset 5).
// A command word is taken on a clock edge with start high and busy low; all
// fields are captured then. Only one command is in flight at a time.
// Clear takes effect at the accepting edge, busy never rises.
// Spawn scans slots one per cycle for the first free one and then sends
// the status word for it; when the pool is full the scan stops at the last
// slot and the status word reports not placed.
// Tick visits every slot: a read, then update and write back.
// Draw reads every slot, then checks it; an active slot with a nonzero life
// total also waits for the single 24-step alpha divider, and an active
// last slot with zero total goes through S_DLAST for its record.
// The slot memory is one record per slot, single port, registered read.
// Reset clears the live flags and returns gravity to 5; the record memory
// is not cleared, as records of slots that are not live are never used.
// Each result word appears on the result ports for one cycle under
// result_valid; the receiver cannot stall, so no result is ever held back.
module particle_pool_engine_unit
    import ppe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [23:0] pos_x,
    input  logic [23:0] pos_y,
    input  logic [15:0] vel_x,
    input  logic [15:0] vel_y,
    input  logic [15:0] lifetime,
    input  logic [7:0]  radius,
    input  logic [31:0] color_rgba,
    input  logic [15:0] frame_time,
    output logic        result_valid,
    output logic        kind,
    output logic        placed,
    output logic [5:0]  slot,
    output logic [15:0] pixel_x,
    output logic [15:0] pixel_y,
    output logic [7:0]  size_out,
    output logic [31:0] faded_rgba,
    output logic        last
);
    typedef enum logic [2:0] {
        S_IDLE, S_SPAWN, S_TREAD, S_TCALC, S_DREAD, S_DCHK, S_DDIV, S_DLAST
    } state_t;

    state_t state_reg;
    logic [15:0] grav_reg;
    logic [POOL_SLOTS-1:0] live_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic [15:0] dt_reg;
    part_t spw_reg;
    part_t mem [POOL_SLOTS];
    part_t rd_reg;
    part_t wr_data;
    logic  wr_en;
    logic [SLOT_W-1:0] rd_addr;
    logic  rd_en;
    // pending draw record: emitted when the next live one is found or at end
    logic        pend_reg;
    logic [5:0]  pslot_reg;
    logic [15:0] px_reg, py_reg;
    logic [7:0]  psz_reg;
    logic [31:0] pcol_reg;

    logic        rv_reg, kind_reg, placed_reg, last_reg;
    logic [5:0]  slot_reg;
    logic [15:0] pxo_reg, pyo_reg;
    logic [7:0]  szo_reg;
    logic [31:0] colo_reg;

    logic        div_go, div_done;
    logic [7:0]  div_q;
    logic [23:0] div_num;
    logic        at_end;
    logic        pwr;

    assign at_end = (idx_reg == SLOT_W'(POOL_SLOTS - 1));
    assign pwr    = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = {{16{grav_reg[15]}}, grav_reg};
    assign busy   = (state_reg != S_IDLE);

    // life clamped to total before scaling
    assign div_num = {16'd0, rd_reg.color[7:0]} *
                     {8'd0, ((rd_reg.life > rd_reg.total) ? rd_reg.total : rd_reg.life)};
    assign div_go  = (state_reg == S_DCHK) && live_reg[idx_reg] && (rd_reg.total != 16'd0);

    ppe_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (div_go),
        .num  (div_num),
        .den  (rd_reg.total),
        .done (div_done),
        .quo  (div_q)
    );

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = idx_reg;
        wr_en   = 1'b0;
        wr_data = rd_reg;
        if (state_reg == S_TREAD || state_reg == S_DREAD)
            rd_en = 1'b1;
        if (state_reg == S_SPAWN && !live_reg[idx_reg])
        begin
            wr_en   = 1'b1;
            wr_data = spw_reg;
        end
        if (state_reg == S_TCALC && live_reg[idx_reg])
        begin
            wr_en      = 1'b1;
            wr_data.x  = sat24(rd_reg.x, rd_reg.vx);
            wr_data.y  = sat24(rd_reg.y, rd_reg.vy);
            wr_data.vy = sat16(rd_reg.vy, grav_reg);
            wr_data.life = rd_reg.life - dt_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[idx_reg] <= wr_data;
        if (rd_en)
            rd_reg <= mem[rd_addr];
    end

    // command fields are captured every idle cycle; the accepting edge
    // leaves the accepted word in dt_reg and spw_reg
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            grav_reg   <= GRAVITY_RESET;
            live_reg   <= '0;
            idx_reg    <= '0;
            pend_reg   <= 1'b0;
            rv_reg     <= 1'b0;
        end
        else
        begin
            rv_reg <= 1'b0;
            if (pwr && paddr == {REG_GRAVITY, 1'b0})
                grav_reg <= pwdata[15:0];
            case (state_reg)
                S_IDLE:
                begin
                    idx_reg  <= '0;
                    pend_reg <= 1'b0;
                    dt_reg   <= frame_time;
                    spw_reg  <= {pos_x, pos_y, vel_x, vel_y, lifetime, lifetime,
                                 radius, color_rgba};
                    if (start)
                    begin
                        case (cmd_t'(command))
                            CMD_CLEAR: live_reg <= '0;
                            CMD_SPAWN: state_reg <= S_SPAWN;
                            CMD_TICK:  state_reg <= S_TREAD;
                            CMD_DRAW:  state_reg <= S_DREAD;
                            default:   state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_SPAWN:
                begin
                    if (!live_reg[idx_reg] || at_end)
                    begin
                        rv_reg     <= 1'b1;
                        kind_reg   <= 1'b0;
                        placed_reg <= !live_reg[idx_reg];
                        slot_reg   <= live_reg[idx_reg] ? 6'd0 : 6'(idx_reg);
                        pxo_reg    <= '0;
                        pyo_reg    <= '0;
                        szo_reg    <= '0;
                        colo_reg   <= '0;
                        last_reg   <= 1'b0;
                        if (!live_reg[idx_reg])
                            live_reg[idx_reg] <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                S_TREAD: state_reg <= S_TCALC;
                S_TCALC:
                begin
                    if (live_reg[idx_reg] && rd_reg.life <= dt_reg)
                        live_reg[idx_reg] <= 1'b0;
                    if (at_end)
                        state_reg <= S_IDLE;
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_TREAD;
                    end
                end
                S_DREAD: state_reg <= S_DCHK;
                S_DCHK:
                begin
                    if (live_reg[idx_reg])
                    begin
                        if (pend_reg)
                        begin
                            rv_reg     <= 1'b1;
                            kind_reg   <= 1'b1;
                            placed_reg <= 1'b0;
                            slot_reg   <= pslot_reg;
                            pxo_reg    <= px_reg;
                            pyo_reg    <= py_reg;
                            szo_reg    <= psz_reg;
                            colo_reg   <= pcol_reg;
                            last_reg   <= 1'b0;
                        end
                        pend_reg  <= 1'b1;
                        pslot_reg <= 6'(idx_reg);
                        px_reg    <= trunc_px(rd_reg.x);
                        py_reg    <= trunc_px(rd_reg.y);
                        psz_reg   <= rd_reg.size;
                        pcol_reg  <= {rd_reg.color[31:8], 8'd0};
                        if (rd_reg.total != 16'd0)
                            state_reg <= S_DDIV;
                        else if (at_end)
                            state_reg <= S_DLAST;
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_DREAD;
                        end
                    end
                    else if (at_end)
                    begin
                        if (pend_reg)
                        begin
                            rv_reg     <= 1'b1;
                            kind_reg   <= 1'b1;
                            placed_reg <= 1'b0;
                            slot_reg   <= pslot_reg;
                            pxo_reg    <= px_reg;
                            pyo_reg    <= py_reg;
                            szo_reg    <= psz_reg;
                            colo_reg   <= pcol_reg;
                            last_reg   <= 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_DREAD;
                    end
                end
                S_DDIV:
                begin
                    if (div_done)
                    begin
                        if (at_end)
                        begin
                            rv_reg     <= 1'b1;
                            kind_reg   <= 1'b1;
                            placed_reg <= 1'b0;
                            slot_reg   <= pslot_reg;
                            pxo_reg    <= px_reg;
                            pyo_reg    <= py_reg;
                            szo_reg    <= psz_reg;
                            colo_reg   <= {pcol_reg[31:8], div_q};
                            last_reg   <= 1'b1;
                            state_reg  <= S_IDLE;
                        end
                        else
                        begin
                            pcol_reg  <= {pcol_reg[31:8], div_q};
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_DREAD;
                        end
                    end
                end
                // final slot live with zero total: its record goes out in the
                // cycle after the record before it
                S_DLAST:
                begin
                    rv_reg     <= 1'b1;
                    kind_reg   <= 1'b1;
                    placed_reg <= 1'b0;
                    slot_reg   <= pslot_reg;
                    pxo_reg    <= px_reg;
                    pyo_reg    <= py_reg;
                    szo_reg    <= psz_reg;
                    colo_reg   <= pcol_reg;
                    last_reg   <= 1'b1;
                    state_reg  <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign result_valid = rv_reg;
    assign kind         = kind_reg;
    assign placed       = placed_reg;
    assign slot         = slot_reg;
    assign pixel_x      = pxo_reg;
    assign pixel_y      = pyo_reg;
    assign size_out     = szo_reg;
    assign faded_rgba   = colo_reg;
    assign last         = last_reg;
endmodule

@@ rtl/core/ppe_checker.sv @@
module ppe_checker
    import ppe_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] command,
    input logic       result_valid,
    input logic       kind,
    input logic       placed,
    input logic       last
);
    // every command but clear keeps the block busy after it is taken
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command != CMD_CLEAR) |=> busy)
        else $error("not busy after command");
    // spawn status never carries last
    a_spawn_no_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !kind) |-> !last)
        else $error("spawn status with last");
    // draw records never carry placed
    a_draw_no_placed: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && kind) |-> !placed)
        else $error("draw record with placed");
    // after the last record the block frees up
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |-> !busy)
        else $error("busy after last record");
endmodule

bind particle_pool_engine_unit ppe_checker u_ppe_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .command     (command),
    .result_valid(result_valid),
    .kind        (kind),
    .placed      (placed),
    .last        (last)
);
